// ===== rtl/core/ifd_pkg.sv =====
// Shared types and constants of the impact and fall detector.
// Used by ifd_sqrt and impact_fall_detector; depends on nothing else.
package ifd_pkg;

	// Datapath widths.
	localparam int AXIS_W  = 12;
	localparam int SQ_W    = 23;
	localparam int SUM_W   = 24;
	localparam int MAG_W   = 12;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int REM_W   = 14;
	localparam int DIR_W   = 4;

	// Root unit produces one result bit per step.
	localparam int ROOT_STEPS = MAG_W;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_WARN   = 2'd0;
	localparam logic [1:0] REG_IMPACT = 2'd1;
	localparam logic [1:0] REG_HOLD   = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0] WARN_RST   = 16'd2500;
	localparam logic [CFG_W-1:0] IMPACT_RST = 16'd10000;
	localparam logic [CFG_W-1:0] HOLD_RST   = 16'd1000;

	// Impact direction codes.
	localparam logic [DIR_W-1:0] DIR_NONE = 4'd0;
	localparam logic [DIR_W-1:0] DIR_EN   = 4'd1;
	localparam logic [DIR_W-1:0] DIR_ES   = 4'd2;
	localparam logic [DIR_W-1:0] DIR_WN   = 4'd3;
	localparam logic [DIR_W-1:0] DIR_WS   = 4'd4;
	localparam logic [DIR_W-1:0] DIR_NE   = 4'd5;
	localparam logic [DIR_W-1:0] DIR_NW   = 4'd6;
	localparam logic [DIR_W-1:0] DIR_SE   = 4'd7;
	localparam logic [DIR_W-1:0] DIR_SW   = 4'd8;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_UPDATE,
		ST_OUT
	} ifd_state_t;

	// Status of the root unit toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} ifd_sqrt_stat_t;

endpackage

// ===== rtl/core/ifd_sqrt.sv =====
// Bit-serial restoring integer square root, one result bit per cycle.
// Depends on ifd_pkg for widths and the status struct.
module ifd_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ifd_pkg::SUM_W-1:0]    radicand,
	output logic [ifd_pkg::MAG_W-1:0]    root,
	output ifd_pkg::ifd_sqrt_stat_t      stat
);
	import ifd_pkg::*;

	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SUM_W-1:0]   rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [MAG_W-1:0]   root_q;

	logic [REM_W+1:0]   rem_sh;
	logic [REM_W+1:0]   trial;
	logic [REM_W+1:0]   diff;
	logic               take;

	// One trial subtraction per step on the partial remainder.
	always_comb begin
		rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		take   = (rem_sh >= trial);
		diff   = rem_sh - trial;
	end

	// Control of the step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == 4'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// Remainder, root and radicand shift.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SUM_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= diff[REM_W-1:0];
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// The done pulse closes a busy run and never overlaps it.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("root done without a preceding run");

	// During a run the step counter stays below the number of steps.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q < 4'(ROOT_STEPS)))
		else $error("root step counter out of range");

	// A started run is busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("root unit did not start");

endmodule

// ===== rtl/core/impact_fall_detector.sv =====
// Top level of the impact and fall detector: sequencer, shared squarer, state update.
// Depends on ifd_pkg and ifd_sqrt.
//
// Channel   Dir  Handshake           Contents
// s_*       in   s_tvalid/s_tready   one accelerometer sample and time per item
// m_*       out  m_tvalid/m_tready   magnitude, warning, peak, direction, halted
// APB       in   psel/penable        warn_threshold, impact_threshold, hold_ms
//
// An accepted item passes through the shared 12x12 squarer and accumulator,
// the bit-serial root unit (twelve steps, then the root is handed over), the
// state update and the load of the output register. The next item is
// accepted only after that load. Once halted, an item skips the squarer,
// root unit and state update and goes straight to the output load.
// Reset clears the state and restores register defaults. A result waiting in
// the output register does not block the next item; only a second finished
// result waits for it.
module impact_fall_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// accel_x [11:0], accel_y [23:12], accel_z [35:24], now_ms [67:36], zero [71:68]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// magnitude [11:0], warning [12], peak [24:13], direction [28:25], halted [29],
	// zero [31:30]
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ifd_pkg::*;

	ifd_state_t state_q, state_d;

	// Configuration registers.
	logic [CFG_W-1:0] warn_thr_q;
	logic [CFG_W-1:0] impact_thr_q;
	logic [CFG_W-1:0] hold_q;

	// Captured item.
	logic signed [AXIS_W-1:0] x_q, y_q, z_q;
	logic [TIME_W-1:0]        now_q;

	// Squarer and accumulator.
	logic [2:0]               sq_cnt_q;
	logic signed [AXIS_W-1:0] mul_op;
	logic signed [2*AXIS_W-1:0] mul_res;
	logic [SQ_W-1:0]          prod_q;
	logic [SUM_W-1:0]         sum_q;

	// Root unit.
	logic                 sqrt_start;
	logic [MAG_W-1:0]     sqrt_root;
	ifd_sqrt_stat_t       sqrt_stat;
	logic [MAG_W-1:0]     mag_q;

	// Detector state.
	logic             warn_q;
	logic [MAG_W-1:0] peak_q;
	logic [TIME_W-1:0] peak_time_q;
	logic [TIME_W-1:0] trigger_q;
	logic [DIR_W-1:0] dir_q;
	logic             halted;

	// Output register.
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_load;
	logic        in_accept;

	// Update datapath.
	logic [TIME_W-1:0]   age_peak, age_trig, hold_ext;
	logic                above_warn, above_impact, new_peak, expired;
	logic [AXIS_W:0]     ax, ay;
	logic                x_pos, y_pos;
	logic [DIR_W-1:0]    dir_new;

	logic       cfg_wr;

	assign halted    = (dir_q != DIR_NONE);
	assign in_accept = s_tvalid && s_tready;

	// Configuration port: writes on the access cycle, reads by index.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_thr_q   <= WARN_RST;
			impact_thr_q <= IMPACT_RST;
			hold_q       <= HOLD_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WARN:   warn_thr_q   <= pwdata[CFG_W-1:0];
				REG_IMPACT: impact_thr_q <= pwdata[CFG_W-1:0];
				REG_HOLD:   hold_q       <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WARN:   prdata = {16'd0, warn_thr_q};
			REG_IMPACT: prdata = {16'd0, impact_thr_q};
			REG_HOLD:   prdata = {16'd0, hold_q};
			default:    prdata = '0;
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = halted ? ST_OUT : ST_SQUARE;
			end
			ST_SQUARE: begin
				if (sq_cnt_q == 3'd4) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (sqrt_stat.done) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready   = 1'b0;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready   = 1'b1;
			ST_SQUARE: sqrt_start = (sq_cnt_q == 3'd4);
			ST_OUT:    out_load   = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q   <= s_tdata[11:0];
			y_q   <= s_tdata[23:12];
			z_q   <= s_tdata[35:24];
			now_q <= s_tdata[67:36];
		end
	end

	// Shared squarer: one axis per cycle, the product summed in the next cycle.
	always_comb begin
		unique case (sq_cnt_q)
			3'd0:    mul_op = x_q;
			3'd1:    mul_op = y_q;
			default: mul_op = z_q;
		endcase
		mul_res = mul_op * mul_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (in_accept) begin
			sq_cnt_q <= '0;
		end else if (state_q == ST_SQUARE) begin
			sq_cnt_q <= sq_cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQUARE) begin
			prod_q <= mul_res[SQ_W-1:0];
			if (sq_cnt_q == 3'd0) sum_q <= '0;
			else if (sq_cnt_q != 3'd4) sum_q <= sum_q + {1'b0, prod_q};
		end
	end

	ifd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.root     (sqrt_root),
		.stat     (sqrt_stat)
	);

	// Magnitude of the item; zero while halted.
	always_ff @(posedge clk) begin
		if (in_accept) mag_q <= '0;
		else if (sqrt_stat.done) mag_q <= sqrt_root;
	end

	// Threshold, hold time and direction decisions.
	always_comb begin
		hold_ext     = {16'd0, hold_q};
		age_peak     = now_q - peak_time_q;
		age_trig     = now_q - trigger_q;
		above_warn   = {4'd0, mag_q} > warn_thr_q;
		above_impact = {4'd0, mag_q} > impact_thr_q;
		new_peak     = (mag_q > peak_q) || (age_peak > hold_ext);
		expired      = (age_trig >= hold_ext);
		ax = x_q[AXIS_W-1] ? -{x_q[AXIS_W-1], x_q} : {x_q[AXIS_W-1], x_q};
		ay = y_q[AXIS_W-1] ? -{y_q[AXIS_W-1], y_q} : {y_q[AXIS_W-1], y_q};
		x_pos = !x_q[AXIS_W-1] && (x_q != '0);
		y_pos = !y_q[AXIS_W-1] && (y_q != '0);
		if (ax > ay) begin
			if (x_pos) dir_new = y_pos ? DIR_EN : DIR_ES;
			else       dir_new = y_pos ? DIR_WN : DIR_WS;
		end else begin
			if (y_pos) dir_new = x_pos ? DIR_NE : DIR_NW;
			else       dir_new = x_pos ? DIR_SE : DIR_SW;
		end
	end

	// Warning, peak and impact state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q      <= 1'b0;
			peak_q      <= '0;
			peak_time_q <= '0;
			trigger_q   <= '0;
			dir_q       <= DIR_NONE;
		end else if (state_q == ST_UPDATE) begin
			if (above_warn) begin
				trigger_q <= now_q;
				warn_q    <= 1'b1;
				if (new_peak) begin
					peak_q      <= mag_q;
					peak_time_q <= now_q;
				end
			end else if (expired) begin
				warn_q <= 1'b0;
				peak_q <= '0;
			end
			if (above_impact) dir_q <= dir_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= {2'b00, halted, dir_q, peak_q, warn_q, mag_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The squarer and root unit never run while the input side is open.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sqrt_stat.busy)
		else $error("root unit busy while accepting an item");

	// A latched impact direction never changes.
	a_dir_hold: assert property (@(posedge clk) disable iff (!arst_n)
		halted |=> (dir_q == $past(dir_q)))
		else $error("impact direction changed after halt");

	// Without an active warning there is no recorded peak.
	a_peak_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!warn_q |-> (peak_q == '0))
		else $error("peak held without warning");

	// A root result arrives only while the sequencer waits for it.
	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_stat.done |-> (state_q == ST_ROOT))
		else $error("root result outside the root state");

endmodule
